// ----- rtl/core/sdes_pkg.sv -----
package sdes_pkg;

  // input sample width, Q1.(SAMPLE_BITS-1)
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned OUT_W = 24;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd2;

  localparam logic [14:0] DEADZONE_RST = 15'd1638;
  localparam logic [15:0] EXPO_RST     = 16'd0;
  localparam logic [15:0] RATE_RST     = 16'd256;

  // fixed-point constants
  localparam logic [15:0] ONE_Q15  = 16'h8000;
  localparam logic [31:0] HALF_Q15 = 32'h0000_4000;
  localparam logic [31:0] RATE_RND = 32'd128;

  // divider: 17 quotient bits, a few per pipeline stage
  localparam int unsigned DIV_QBITS  = 17;
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = (DIV_QBITS + DIV_STEPS - 1) / DIV_STEPS;

  // front stage + divider + curve stages
  localparam int unsigned CURVE_STAGES = 5;
  localparam int unsigned LATENCY      = 1 + DIV_STAGES + CURVE_STAGES;

  typedef struct packed {
    logic valid;
    logic zero;
    logic neg;
  } tag_t;

  typedef struct packed {
    logic [14:0] deadzone;
    logic [15:0] den;        // 1.0 - deadzone
    logic [15:0] expo;       // clamped to 1.0
    logic [15:0] one_m_expo; // 1.0 - expo
    logic [15:0] rate;
  } cfg_t;

endpackage

// ----- rtl/core/stick_deadzone_expo_shaper_unit.sv -----
// stick deadzone and expo shaper: one signed stick sample in, one shaped and
// rate-scaled value out, no state between samples. a sample is taken on every
// clock edge with start_i high (busy_o stays low, the pipeline never stalls)
// and its result shows on shaped_axis_o for exactly one cycle with done_o high,
// in input order. the receiver cannot hold results off, so one sample per
// clock in gives one result per clock out. the pipeline holds the front stage
// (magnitude and deadzone test), six stages of the restoring divider that
// stretches the travel beyond the deadzone (three quotient bits per stage),
// and five stages for square, cube, blend and output gain.
// registers: 0 deadzone (q0.15), 1 expo (q1.15, above 1.0 saturates),
// 2 rate_scale (q8.8); index 3 is ignored. write them only with the pipeline
// empty; a write takes effect on the next clock.
module stick_deadzone_expo_shaper_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  logic signed [sdes_pkg::SAMPLE_BITS-1:0] raw_axis_i,
  output logic                                    done_o,
  output logic signed [sdes_pkg::OUT_W-1:0]       shaped_axis_o,
  input  logic                                    cfg_we_i,
  input  logic [sdes_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [sdes_pkg::CFG_DATA_W-1:0]         cfg_wdata_i
);
  import sdes_pkg::*;

  cfg_t        cfg;
  tag_t        front_tag;
  logic [15:0] front_num;
  tag_t        div_tag;
  logic [16:0] div_quo;
  logic        accept;

  // fully pipelined, every cycle can take a transfer
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  sdes_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // magnitude, deadzone test, travel beyond the deadzone
  sdes_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .raw_axis_i(raw_axis_i),
    .cfg_i     (cfg),
    .tag_o     (front_tag),
    .num_o     (front_num)
  );

  // rounded rescale of the travel to 0..1
  sdes_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tag_i (front_tag),
    .num_i (front_num),
    .cfg_i (cfg),
    .tag_o (div_tag),
    .quo_o (div_quo)
  );

  // expo blend, sign and output gain
  sdes_curve u_curve (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_i        (div_tag),
    .quo_i        (div_quo),
    .cfg_i        (cfg),
    .done_o       (done_o),
    .shaped_axis_o(shaped_axis_o)
  );

  // every accepted transfer comes out after the fixed latency, nothing else does
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(accept && rst_ni, LATENCY))
    else $error("result strobe out of step with accepted samples");

endmodule

// ----- rtl/core/sdes_cfg.sv -----
module sdes_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sdes_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdes_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output sdes_pkg::cfg_t                 cfg_o
);
  import sdes_pkg::*;

  logic [14:0] deadzone_q;
  logic [15:0] expo_q;
  logic [15:0] rate_q;
  logic [15:0] expo_clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= DEADZONE_RST;
      expo_q     <= EXPO_RST;
      rate_q     <= RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEADZONE: deadzone_q <= cfg_wdata_i[14:0];
        REG_EXPO:     expo_q     <= cfg_wdata_i[15:0];
        REG_RATE:     rate_q     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // weights above 1.0 saturate
  assign expo_clamped = (expo_q > ONE_Q15) ? ONE_Q15 : expo_q;

  assign cfg_o.deadzone   = deadzone_q;
  assign cfg_o.den        = ONE_Q15 - {1'b0, deadzone_q};
  assign cfg_o.expo       = expo_clamped;
  assign cfg_o.one_m_expo = ONE_Q15 - expo_clamped;
  assign cfg_o.rate       = rate_q;

endmodule

// ----- rtl/core/sdes_front.sv -----
module sdes_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic signed [sdes_pkg::SAMPLE_BITS-1:0] raw_axis_i,
  input  sdes_pkg::cfg_t                       cfg_i,
  output sdes_pkg::tag_t                       tag_o,
  output logic [15:0]                          num_o
);
  import sdes_pkg::*;

  logic [SAMPLE_BITS-1:0] raw_u;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS+7:0] mag_ext;
  logic [15:0]            m;
  tag_t                   tag_d, tag_q;
  logic [15:0]            num_d, num_q;

  always_comb begin
    raw_u   = unsigned'(raw_axis_i);
    // most negative sample gives exactly 1.0
    mag     = raw_u[SAMPLE_BITS-1] ? (~raw_u + 1'b1) : raw_u;
    mag_ext = {mag, 8'b0} >> (SAMPLE_BITS - 8);
    m       = mag_ext[15:0];

    tag_d.valid = valid_i;
    tag_d.zero  = (m <= {1'b0, cfg_i.deadzone});
    tag_d.neg   = raw_u[SAMPLE_BITS-1];
    num_d       = m - {1'b0, cfg_i.deadzone};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

  assign tag_o = tag_q;
  assign num_o = num_q;

endmodule

// ----- rtl/core/sdes_div.sv -----
module sdes_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sdes_pkg::tag_t tag_i,
  input  logic [15:0]    num_i,
  input  sdes_pkg::cfg_t cfg_i,
  output sdes_pkg::tag_t tag_o,
  output logic [16:0]    quo_o
);
  import sdes_pkg::*;

  // restoring division of (num * 2^15 + den/2) by den, a few bits per stage
  tag_t        tag_in [DIV_STAGES];
  logic [14:0] rem_in [DIV_STAGES];
  logic [16:0] quo_in [DIV_STAGES];
  logic [16:0] bits_in[DIV_STAGES];

  tag_t        tag_q  [DIV_STAGES];
  logic [14:0] rem_d  [DIV_STAGES];
  logic [14:0] rem_q  [DIV_STAGES];
  logic [16:0] quo_d  [DIV_STAGES];
  logic [16:0] quo_q  [DIV_STAGES];
  logic [16:0] bits_d [DIV_STAGES];
  logic [16:0] bits_q [DIV_STAGES];

  always_comb begin
    // top dividend bits are below den, so they seed the remainder
    tag_in[0]  = tag_i;
    rem_in[0]  = {1'b0, num_i[15:2]};
    quo_in[0]  = '0;
    bits_in[0] = {num_i[1:0], cfg_i.den[15:1]};
    for (int s = 1; s < DIV_STAGES; s++) begin
      tag_in[s]  = tag_q[s-1];
      rem_in[s]  = rem_q[s-1];
      quo_in[s]  = quo_q[s-1];
      bits_in[s] = bits_q[s-1];
    end
  end

  always_comb begin
    logic [15:0] trial;
    logic [14:0] rem_v;
    logic [16:0] quo_v;
    logic [16:0] bits_v;
    trial = '0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_v  = rem_in[s];
      quo_v  = quo_in[s];
      bits_v = bits_in[s];
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (s * DIV_STEPS + j < DIV_QBITS) begin
          trial  = {rem_v, bits_v[16]};
          bits_v = {bits_v[15:0], 1'b0};
          if (trial >= cfg_i.den) begin
            rem_v = 15'(trial - cfg_i.den);
            quo_v = {quo_v[15:0], 1'b1};
          end else begin
            rem_v = trial[14:0];
            quo_v = {quo_v[15:0], 1'b0};
          end
        end
      end
      rem_d[s]  = rem_v;
      quo_d[s]  = quo_v;
      bits_d[s] = bits_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        tag_q[s] <= '0;
      end
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        tag_q[s] <= tag_in[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_q[s]  <= rem_d[s];
      quo_q[s]  <= quo_d[s];
      bits_q[s] <= bits_d[s];
    end
  end

  assign tag_o = tag_q[DIV_STAGES-1];
  assign quo_o = quo_q[DIV_STAGES-1];

  // final remainder always below the divisor for a live item
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_q[DIV_STAGES-1].valid && !tag_q[DIV_STAGES-1].zero
      |-> ({1'b0, rem_q[DIV_STAGES-1]} < cfg_i.den))
    else $error("divider remainder not below divisor");

endmodule

// ----- rtl/core/sdes_curve.sv -----
module sdes_curve (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sdes_pkg::tag_t                         tag_i,
  input  logic [16:0]                            quo_i,
  input  sdes_pkg::cfg_t                         cfg_i,
  output logic                                   done_o,
  output logic signed [sdes_pkg::OUT_W-1:0]      shaped_axis_o
);
  import sdes_pkg::*;

  tag_t tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;

  // stage 1: clamp, square
  logic [15:0] x1_d, x1_q, x2_d, x2_q;
  logic [31:0] sq;
  // stage 2: cube
  logic [15:0] x_b_q, x3_d, x3_q;
  logic [31:0] cu;
  // stage 3: blend products
  logic [31:0] p_lin_d, p_lin_q, p_cub_d, p_cub_q;
  // stage 4: blend sum
  logic [31:0] y_sum;
  logic [15:0] y_d, y_q;
  // stage 5: rate gain and sign
  logic [31:0] rs;
  logic [OUT_W-1:0] r_mag;
  logic [OUT_W-1:0] out_d, out_q;

  always_comb begin
    x1_d  = (quo_i > {1'b0, ONE_Q15}) ? ONE_Q15 : quo_i[15:0];
    sq    = x1_d * x1_d;
    x2_d  = 16'((sq + HALF_Q15) >> 15);

    cu    = x2_q * x1_q;
    x3_d  = 16'((cu + HALF_Q15) >> 15);

    p_lin_d = cfg_i.one_m_expo * x_b_q;
    p_cub_d = cfg_i.expo * x3_q;

    y_sum = p_lin_q + p_cub_q + HALF_Q15;
    y_d   = 16'(y_sum >> 15);

    rs    = y_q * cfg_i.rate;
    r_mag = 24'((rs + RATE_RND) >> 8);
    if (tag4_q.zero) begin
      out_d = '0;
    end else if (tag4_q.neg) begin
      out_d = ~r_mag + 1'b1;
    end else begin
      out_d = r_mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
      tag5_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
      tag5_q <= tag4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q    <= x1_d;
    x2_q    <= x2_d;
    x_b_q   <= x1_q;
    x3_q    <= x3_d;
    p_lin_q <= p_lin_d;
    p_cub_q <= p_cub_d;
    y_q     <= y_d;
    out_q   <= out_d;
  end

  assign done_o        = tag5_q.valid;
  assign shaped_axis_o = signed'(out_q);

  a_square_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag1_q.valid |-> (x2_q <= ONE_Q15))
    else $error("square above full scale");

  a_blend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag4_q.valid |-> (y_q <= ONE_Q15))
    else $error("blend above full scale");

  a_dead_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && tag5_q.zero |-> (out_q == '0))
    else $error("deadzone sample gave nonzero result");

  a_sign_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_q[OUT_W-1] |-> tag5_q.neg)
    else $error("negative result from positive sample");

endmodule
